// ----- hw/rtl/bpcw_pkg.sv -----
// Package with shared types, constants and the CRC and whitening step functions.
`timescale 1ns / 1ps

package bpcw_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [23:0] CRC_TAPS      = 24'hDA6000;
  localparam logic [7:0]  LFSR_TAPS     = 8'h88;
  localparam logic [5:0]  CHANNEL_RESET = 6'd37;
  localparam logic [23:0] CRC_SEED_RESET = 24'hAAAAAA;

  localparam logic [1:0] CFG_CHANNEL  = 2'd0;
  localparam logic [1:0] CFG_CRC_SEED = 2'd1;

  // Back end sequence: the data byte, then three CRC bytes.
  typedef enum logic [1:0] {
    PH_DATA,
    PH_CRC0,
    PH_CRC1,
    PH_CRC2
  } phase_t;

  // One queue entry: the PDU byte and, on the last byte, the finished CRC.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [23:0] crc;
  } q_entry_t;

  typedef struct packed {
    logic [6:0] lfsr;
    logic [7:0] mask;
  } wht_t;

  function automatic logic [23:0] crc_byte(input logic [23:0] crc_in, input logic [7:0] d);
    logic [23:0] crc;
    logic        ob;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      ob  = crc[0];
      crc = crc >> 1;
      if (ob != d[i]) begin
        crc = crc ^ CRC_TAPS;
      end
    end
    return crc;
  endfunction

  function automatic wht_t whiten_step(input logic [6:0] lfsr_in);
    wht_t r;
    logic [7:0] l;
    l = {1'b0, lfsr_in};
    r.mask = '0;
    for (int i = 0; i < 8; i++) begin
      if (l[0]) begin
        // Bit 7 of the tap pattern shifts back into bit 6 of the register.
        l = l ^ LFSR_TAPS;
        r.mask[i] = 1'b1;
      end
      l = l >> 1;
    end
    r.lfsr = l[6:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/bpcw_front.sv -----
// Front end: takes PDU bytes, runs the CRC and marks packet boundaries.
`timescale 1ns / 1ps

module bpcw_front import bpcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [23:0] crc_seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_pdu,
  output logic        push,
  output q_entry_t    push_entry,
  input  logic        q_full
);

  logic        in_packet_r, in_packet_nxt;
  logic [23:0] crc_r, crc_nxt;
  logic [23:0] crc_start;

  always_comb begin
    in_ready  = !q_full;
    push      = in_valid && in_ready;
    // The first byte of a packet starts from the configured seed.
    crc_start = in_packet_r ? crc_r : crc_seed;
    crc_nxt   = crc_byte(crc_start, in_data_byte);
    in_packet_nxt = in_packet_r;
    if (push) begin
      in_packet_nxt = !in_end_of_pdu;
    end
    push_entry.data = in_data_byte;
    push_entry.last = in_end_of_pdu;
    push_entry.crc  = crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
    end else begin
      in_packet_r <= in_packet_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      crc_r <= crc_nxt;
    end
  end

endmodule

// ----- hw/rtl/bpcw_fifo.sv -----
// Short queue between the front end and the back end.
`timescale 1ns / 1ps

module bpcw_fifo import bpcw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output q_entry_t head
);

  q_entry_t       mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   count_r, count_nxt;

  always_comb begin
    full      = (count_r == (QAW+1)'(QDEPTH));
    not_empty = (count_r != '0);
    head      = mem_r[rptr_r];
    count_nxt = count_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

endmodule

// ----- hw/rtl/bpcw_back.sv -----
// Back end: whitens data and CRC bytes and holds the output register.
`timescale 1ns / 1ps

module bpcw_back import bpcw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [5:0] channel,
  input  logic       q_not_empty,
  input  q_entry_t   q_head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  phase_t      state_r, state_nxt;
  logic        pkt_r, pkt_nxt;
  logic [6:0]  lfsr_r;
  logic [23:0] crc_hold_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic        load_en;
  logic        emit;
  logic [6:0]  lfsr_cur;
  logic [7:0]  src;
  wht_t        wr;

  always_comb begin
    load_en   = !out_valid_r || out_ready;
    pop       = 1'b0;
    emit      = 1'b0;
    state_nxt = state_r;
    pkt_nxt   = pkt_r;
    src       = q_head.data;
    unique case (state_r)
      PH_DATA: begin
        src  = q_head.data;
        pop  = load_en && q_not_empty;
        emit = pop;
        if (pop) begin
          pkt_nxt = 1'b1;
          if (q_head.last) begin
            state_nxt = PH_CRC0;
          end
        end
      end
      PH_CRC0: begin
        src  = crc_hold_r[7:0];
        emit = load_en;
        if (load_en) begin
          state_nxt = PH_CRC1;
        end
      end
      PH_CRC1: begin
        src  = crc_hold_r[15:8];
        emit = load_en;
        if (load_en) begin
          state_nxt = PH_CRC2;
        end
      end
      PH_CRC2: begin
        src  = crc_hold_r[23:16];
        emit = load_en;
        if (load_en) begin
          state_nxt = PH_DATA;
          pkt_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = PH_DATA;
      end
    endcase
    // A new packet reseeds the whitener from the channel.
    lfsr_cur      = pkt_r ? lfsr_r : {1'b1, channel};
    wr            = whiten_step(lfsr_cur);
    out_valid_nxt = load_en ? emit : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_DATA;
      pkt_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pkt_r       <= pkt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      lfsr_r     <= wr.lfsr;
      out_byte_r <= src ^ wr.mask;
      out_last_r <= (state_r == PH_CRC2);
    end
    if (pop && q_head.last) begin
      crc_hold_r <= q_head.crc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// ----- hw/rtl/ble_pdu_crc_whitener_core.sv -----
// Top level of the BLE PDU CRC-24 and data whitening core.
//
//   Port group   Direction  Handshake           Payload
//   in_*         input      in_valid/in_ready   in_data_byte[7:0], in_end_of_pdu
//   out_*        output     out_valid/out_ready out_byte[7:0], out_last
//   cfg_*        input      cfg_valid/cfg_ready cfg_index[1:0], cfg_data[23:0]
//
// One PDU byte is taken per cycle while the queue is not full; the CRC and the
// whitener each handle a whole byte at once. A last byte yields four output bytes
// (data plus three CRC bytes), and while these go out the four-entry queue keeps
// taking input until it is full. A byte is written from its input transfer into the
// queue and from there into the output register. Reset is synchronous and clears
// the queue, the packet state and the output valid flag; config resets to channel
// 37, seed 0xAAAAAA. Configuration writes are always taken and must be made while
// the core is idle.
`timescale 1ns / 1ps

module ble_pdu_crc_whitener_core import bpcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_pdu,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [5:0]  channel_r;
  logic [23:0] crc_seed_r;
  logic        push, q_full, pop, q_not_empty;
  q_entry_t    push_entry, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r  <= CHANNEL_RESET;
      crc_seed_r <= CRC_SEED_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CHANNEL:  channel_r  <= cfg_data[5:0];
        CFG_CRC_SEED: crc_seed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bpcw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .crc_seed      (crc_seed_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_end_of_pdu (in_end_of_pdu),
    .push          (push),
    .push_entry    (push_entry),
    .q_full        (q_full)
  );

  bpcw_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  bpcw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .channel     (channel_r),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last)
  );

endmodule

// ----- hw/rtl/bpcw_checker.sv -----
// Port-level checker for the core, bound to the top level.
`timescale 1ns / 1ps

module bpcw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_end_of_pdu,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Packets whose last byte has gone in but whose final CRC byte is not yet out.
  logic [3:0] pend_r;
  logic       in_end_xfer, out_end_xfer;

  assign in_end_xfer  = in_valid && in_ready && in_end_of_pdu;
  assign out_end_xfer = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(in_end_xfer) - 4'(out_end_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_last_has_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_end_xfer |-> pend_r != '0)
    else $error("final CRC byte without a finished packet");

  a_no_excess: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd6)
    else $error("too many packets in flight");

endmodule

bind ble_pdu_crc_whitener_core bpcw_checker u_bpcw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_end_of_pdu (in_end_of_pdu),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .out_last      (out_last)
);
